FILE: sv/rgb2hsl_pkg.sv
package rgb2hsl_pkg;

    // Channel and result widths
    localparam int unsigned CH_W     = 8;
    localparam int unsigned DATA_W   = 3 * CH_W;
    localparam int unsigned SUM_W    = CH_W + 1;
    localparam int unsigned DIFF_W   = CH_W + 1;
    localparam int unsigned NRAW_W   = CH_W + 4;
    localparam int unsigned HDEN_W   = CH_W + 3;
    localparam int unsigned HNUM_W   = HDEN_W + CH_W;
    localparam int unsigned SNUM_W   = 2 * CH_W;

    // Divider: quotient bits resolved per pipeline stage
    localparam int unsigned STEP_BITS = 2;
    localparam int unsigned DIV_STEPS = CH_W / STEP_BITS;

    // front, mid, norm, divider input, divider steps, output
    localparam int unsigned NSTG = 4 + DIV_STEPS + 1;

    // Which channel holds the maximum (priority red, green, blue)
    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } sel_t;

    typedef struct packed {
        logic [CH_W-1:0]          mx;
        logic [CH_W-1:0]          mn;
        sel_t                     sel;
        logic signed [DIFF_W-1:0] diff;
    } front_t;

    typedef struct packed {
        logic [SUM_W-1:0]         sum;
        logic [CH_W-1:0]          d;
        logic signed [NRAW_W-1:0] n_raw;
    } mid_t;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [CH_W-1:0]   d;
        logic [HDEN_W-1:0] n;
        logic [HDEN_W-1:0] d6;
    } norm_t;

    // Both dividers travel side by side through the step stages
    typedef struct packed {
        logic [HNUM_W-1:0] hrem;
        logic [HDEN_W-1:0] hden;
        logic [CH_W-1:0]   hq;
        logic [SNUM_W-1:0] srem;
        logic [CH_W-1:0]   sden;
        logic [CH_W-1:0]   sq;
        logic [CH_W-1:0]   light;
        logic              gray;
    } div_t;

endpackage

FILE: sv/rgb_to_hsl_pixel_unit.sv
// RGB to HSL converter, one pixel per word, no kept state.
// Pipeline: nine register stages (max/min, sum/diff, hue offset, numerators, four 2-bit
// divider steps, rounding).
// Throughput: one word per cycle while m_axis_tready is high; the two restoring dividers are
// unrolled into pipeline stages, and each stage drains into a gap ahead of it while stalled.
// Reset: synchronous, active low aresetn clears all stage valid bits only.
module rgb_to_hsl_pixel_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    input  logic [rgb2hsl_pkg::DATA_W-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] hue, [15:8] saturation, [23:16] lightness
    output logic [rgb2hsl_pkg::DATA_W-1:0] m_axis_tdata
);

    localparam int unsigned CH_W   = rgb2hsl_pkg::CH_W;
    localparam int unsigned NSTG   = rgb2hsl_pkg::NSTG;
    localparam int unsigned NDIV   = rgb2hsl_pkg::DIV_STEPS;
    localparam int unsigned DIV0   = 3;
    localparam int unsigned OUT_S  = NSTG - 1;

    // One quotient step pair of both dividers, top bit given by hi
    function automatic rgb2hsl_pkg::div_t div_step(rgb2hsl_pkg::div_t x, logic [2:0] hi);
        logic [rgb2hsl_pkg::HNUM_W-1:0] hsh;
        logic [rgb2hsl_pkg::SNUM_W-1:0] ssh;
        logic [2:0]                     b;
        for (int j = 0; j < rgb2hsl_pkg::STEP_BITS; j++) begin
            b   = hi - 3'(j);
            hsh = rgb2hsl_pkg::HNUM_W'(x.hden) << b;
            ssh = rgb2hsl_pkg::SNUM_W'(x.sden) << b;
            if (x.hrem >= hsh) begin
                x.hrem  = x.hrem - hsh;
                x.hq[b] = 1'b1;
            end
            if (x.srem >= ssh) begin
                x.srem  = x.srem - ssh;
                x.sq[b] = 1'b1;
            end
        end
        return x;
    endfunction

    // ---------------- pipeline control ----------------
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [NSTG:0]   rdy;

    assign rdy[NSTG] = m_axis_tready;

    // A stage takes a new word when empty or when its own word moves on
    for (genvar i = 0; i < NSTG; i++) begin : g_rdy
        assign rdy[i] = !v_reg[i] || rdy[i+1];
    end

    always_comb begin
        v_next = v_reg;
        if (rdy[0]) begin
            v_next[0] = s_axis_tvalid;
        end
        for (int i = 1; i < NSTG; i++) begin
            if (rdy[i]) begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = v_reg[OUT_S];

    // ---------------- stage 0: max, min, sector ----------------
    logic [CH_W-1:0]     red;
    logic [CH_W-1:0]     green;
    logic [CH_W-1:0]     blue;
    rgb2hsl_pkg::front_t front_reg;
    rgb2hsl_pkg::front_t front_next;

    assign red   = s_axis_tdata[CH_W-1:0];
    assign green = s_axis_tdata[2*CH_W-1:CH_W];
    assign blue  = s_axis_tdata[3*CH_W-1:2*CH_W];

    always_comb begin
        front_next = front_reg;
        if (red >= green && red >= blue) begin
            front_next.sel  = rgb2hsl_pkg::SEL_RED;
            front_next.mx   = red;
            front_next.diff = $signed({1'b0, green}) - $signed({1'b0, blue});
        end else if (green >= blue) begin
            front_next.sel  = rgb2hsl_pkg::SEL_GREEN;
            front_next.mx   = green;
            front_next.diff = $signed({1'b0, blue}) - $signed({1'b0, red});
        end else begin
            front_next.sel  = rgb2hsl_pkg::SEL_BLUE;
            front_next.mx   = blue;
            front_next.diff = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        front_next.mn = red;
        if (green < front_next.mn) begin
            front_next.mn = green;
        end
        if (blue < front_next.mn) begin
            front_next.mn = blue;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            front_reg <= front_next;
        end
    end

    // ---------------- stage 1: d, sum, raw hue offset ----------------
    rgb2hsl_pkg::mid_t               mid_reg;
    rgb2hsl_pkg::mid_t               mid_next;
    logic [rgb2hsl_pkg::NRAW_W-1:0]  base;

    always_comb begin
        mid_next.d   = front_reg.mx - front_reg.mn;
        mid_next.sum = {1'b0, front_reg.mx} + {1'b0, front_reg.mn};
        case (front_reg.sel)
            rgb2hsl_pkg::SEL_GREEN: base = {3'b000, mid_next.d, 1'b0};
            rgb2hsl_pkg::SEL_BLUE:  base = {2'b00, mid_next.d, 2'b00};
            default:                base = '0;
        endcase
        // diff is signed, so the size cast sign-extends it
        mid_next.n_raw = $signed(base) + rgb2hsl_pkg::NRAW_W'(front_reg.diff);
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            mid_reg <= mid_next;
        end
    end

    // ---------------- stage 2: 6d and wrapped hue offset ----------------
    rgb2hsl_pkg::norm_t              norm_reg;
    rgb2hsl_pkg::norm_t              norm_next;
    logic [rgb2hsl_pkg::NRAW_W-1:0]  n_wrap;

    always_comb begin
        norm_next.sum = mid_reg.sum;
        norm_next.d   = mid_reg.d;
        norm_next.d6  = {1'b0, mid_reg.d, 2'b00} + {2'b00, mid_reg.d, 1'b0};
        n_wrap = mid_reg.n_raw;
        if (mid_reg.n_raw < 0) begin
            n_wrap = mid_reg.n_raw + {1'b0, norm_next.d6};
        end
        norm_next.n = n_wrap[rgb2hsl_pkg::HDEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            norm_reg <= norm_next;
        end
    end

    // ---------------- stages 3..7: numerators, then restoring divider steps ----------------
    rgb2hsl_pkg::div_t  div_reg [NDIV+1];
    rgb2hsl_pkg::div_t  div_next [NDIV+1];
    logic [rgb2hsl_pkg::SUM_W-1:0] sden_w;

    always_comb begin
        // stage 3: numerators, denominators, lightness
        div_next[0].hrem  = {norm_reg.n, {CH_W{1'b0}}} - {{CH_W{1'b0}}, norm_reg.n};
        div_next[0].hden  = norm_reg.d6;
        div_next[0].hq    = '0;
        div_next[0].srem  = {norm_reg.d, {CH_W{1'b0}}} - {{CH_W{1'b0}}, norm_reg.d};
        sden_w = (norm_reg.sum < rgb2hsl_pkg::SUM_W'(255)) ? norm_reg.sum
               : rgb2hsl_pkg::SUM_W'(510) - norm_reg.sum;
        div_next[0].sden  = sden_w[CH_W-1:0];
        div_next[0].sq    = '0;
        // sum / 2, half to even
        div_next[0].light = norm_reg.sum[CH_W:1]
                          + {{(CH_W-1){1'b0}}, norm_reg.sum[0] & norm_reg.sum[1]};
        div_next[0].gray  = (norm_reg.d == '0);
        // stages 4..7: two quotient bits each, high bits first
        for (int k = 1; k <= NDIV; k++) begin
            div_next[k] = div_step(div_reg[k-1],
                                   3'(CH_W - 1 - (k - 1) * rgb2hsl_pkg::STEP_BITS));
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k <= NDIV; k++) begin
            if (rdy[DIV0+k]) begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // ---------------- stage 8: rounding, gray override ----------------
    rgb2hsl_pkg::div_t                fin;
    logic [rgb2hsl_pkg::HDEN_W:0]     h_twice;
    logic [CH_W:0]                    s_twice;
    logic [CH_W-1:0]                  hue_r;
    logic [CH_W-1:0]                  sat_r;
    logic [rgb2hsl_pkg::DATA_W-1:0]   out_reg;
    logic [rgb2hsl_pkg::DATA_W-1:0]   out_next;

    always_comb begin
        fin     = div_reg[NDIV];
        h_twice = {fin.hrem[rgb2hsl_pkg::HDEN_W-1:0], 1'b0};
        s_twice = {fin.srem[CH_W-1:0], 1'b0};
        hue_r   = fin.hq;
        sat_r   = fin.sq;
        if (h_twice > {1'b0, fin.hden} || (h_twice == {1'b0, fin.hden} && fin.hq[0])) begin
            hue_r = fin.hq + 1'b1;
        end
        if (s_twice > {1'b0, fin.sden} || (s_twice == {1'b0, fin.sden} && fin.sq[0])) begin
            sat_r = fin.sq + 1'b1;
        end
        if (fin.gray) begin
            hue_r = '0;
            sat_r = '0;
        end
        out_next = {fin.light, sat_r, hue_r};
    end

    always_ff @(posedge aclk) begin
        if (rdy[OUT_S]) begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tdata = out_reg;

`ifndef NO_ASSERTIONS
    // max never below min in the front stage
    a_front_order: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[0] |-> front_reg.mx >= front_reg.mn)
        else $error("front stage max below min");

    // divider inputs: quotients fit in 8 bits
    a_div_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[DIV0] && !div_reg[0].gray) |->
            (div_reg[0].hrem < {div_reg[0].hden, {CH_W{1'b0}}}) &&
            (div_reg[0].srem < {div_reg[0].sden, {CH_W{1'b0}}}))
        else $error("divider input quotient overflow");

    // after the last step both remainders are below their divisors
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[DIV0+NDIV] && !div_reg[NDIV].gray) |->
            (div_reg[NDIV].hrem < rgb2hsl_pkg::HNUM_W'(div_reg[NDIV].hden)) &&
            (div_reg[NDIV].srem < rgb2hsl_pkg::SNUM_W'(div_reg[NDIV].sden)))
        else $error("divider remainder not reduced");

    // a blocked stage keeps its word
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[DIV0] && !rdy[DIV0]) |=> v_reg[DIV0] && $stable(div_reg[0]))
        else $error("blocked divider stage lost its word");
`endif

endmodule
